// ===== rtl/let_pkg.sv =====
// shared constants and register codes for the laplacian edge thresholder
// no dependencies; imported by the top level, let_lap and the testbench files
package let_pkg;

  localparam int MAX_LINE_WIDTH = 1024;
  localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
  localparam int ROW_W          = 11;
  localparam int LINE_WIDTH_W   = 11;
  localparam int THRESH_W       = 8;
  localparam int PIX_W          = 8;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 11;
  // compare width for column against the clamped line width
  localparam int CMP_W = (LINE_WIDTH_W > COL_W + 1) ? LINE_WIDTH_W : COL_W + 1;

  localparam logic [ROW_W-1:0]        ROW_MAX        = '1;
  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = LINE_WIDTH_W'(640);
  localparam logic [THRESH_W-1:0]     THRESH_RST     = THRESH_W'(30);
  localparam logic [PIX_W-1:0]        EDGE_ON        = '1;
  localparam logic [PIX_W-1:0]        EDGE_OFF       = '0;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = CFG_IDX_W'(1);

endpackage

// ===== rtl/laplacian_edge_threshold.sv =====
// top level of the laplacian edge thresholder: position tracking, line stores,
// window, output register; depends on let_pkg, let_ram and let_lap
//
// usage
// - input channel: gray_pixel_i with frame_start_i / frame_end_i, one request
//   per pixel in raster order, taken when in_valid_i is high and in_stall_o low
// - output channel: edge_pixel_o (255 if an edge is found, else 0) with last_of_frame_o,
//   one request for each centre whose lower-right neighbour has arrived
// - config: cfg_we_i writes cfg_data_i to the register at cfg_index_i
//   (0 line width, 1 edge threshold); write only while the block is idle
// - throughput: one pixel per clock while in_stall_o is low, set by the
//   single ram read and write per line store each cycle; first row and column
//   give no result
// - result path: ram read into stage 1 on the accepting edge, then laplacian
//   into the output register when stage 1 advances
// - reset: positions, window and config go to their defaults; the line stores
//   are not cleared and only entries of the current frame reach a result
// - stall: a stalled result holds in the output register; pixels that owe no
//   result keep flowing, the next one that owes a result waits in stage 1 and
//   in_stall_o stays high until the output frees up
module laplacian_edge_threshold (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [let_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [let_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // pixel input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [let_pkg::PIX_W-1:0]      gray_pixel_i,
  input  logic                           frame_start_i,
  input  logic                           frame_end_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [let_pkg::PIX_W-1:0]      edge_pixel_o,
  output logic                           last_of_frame_o
);
  import let_pkg::*;

  // config registers
  logic [LINE_WIDTH_W-1:0] line_width_q;
  logic [THRESH_W-1:0]     thresh_q;

  // raster position of the next pixel
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  // stage 1: pixel waiting for its line store data
  logic             s1_valid_q, s1_valid_d;
  logic [PIX_W-1:0] s1_pix_q;
  logic             s1_fend_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_emit_q;
  logic             s1_full_q;

  // write-to-read bypass when a write and a read of the same column fall in the same cycle
  logic             fwd_hit_q;
  logic [PIX_W-1:0] fwd_up_q;
  logic [PIX_W-1:0] fwd_mid_q;

  // window: middle row at c-2 and c-1, upper row at c-1, lower row at c-1
  logic [PIX_W-1:0] mid_win0_q;
  logic [PIX_W-1:0] mid_win1_q;
  logic [PIX_W-1:0] upper_hold_q;
  logic [PIX_W-1:0] lower_hold_q;

  // output register
  logic             out_valid_q;
  logic [PIX_W-1:0] edge_q;
  logic             last_q;

  logic             accept;
  logic             s1_adv;
  logic             out_free;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [CMP_W-1:0] lw_ext;
  logic [CMP_W-1:0] width_use;
  logic             wrap;
  logic [PIX_W-1:0] up_rdata;
  logic [PIX_W-1:0] mid_rdata;
  logic [PIX_W-1:0] up_now;
  logic [PIX_W-1:0] mid_now;
  logic             lap_edge;

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_emit_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  // column of this pixel, frame start forces the origin
  assign cur_col = frame_start_i ? '0 : col_q;
  assign cur_row = frame_start_i ? '0 : row_q;

  // line width clamped to the supported range
  always_comb begin
    lw_ext = CMP_W'(line_width_q);
    if (lw_ext < CMP_W'(3)) begin
      width_use = CMP_W'(3);
    end else if (lw_ext > CMP_W'(MAX_LINE_WIDTH)) begin
      width_use = CMP_W'(MAX_LINE_WIDTH);
    end else begin
      width_use = lw_ext;
    end
    wrap = (CMP_W'(cur_col) + CMP_W'(1)) >= width_use;
  end

  // next raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (frame_end_i) begin
        col_d = '0;
        row_d = '0;
      end else if (wrap) begin
        col_d = '0;
        row_d = (cur_row == ROW_MAX) ? cur_row : cur_row + ROW_W'(1);
      end else begin
        col_d = cur_col + COL_W'(1);
        row_d = cur_row;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
      thresh_q     <= THRESH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LINE_WIDTH:     line_width_q <= cfg_data_i[LINE_WIDTH_W-1:0];
        REG_EDGE_THRESHOLD: thresh_q     <= cfg_data_i[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        fwd_hit_q <= s1_adv && (s1_col_q == cur_col);
      end
    end
  end

  // stage 1 payload and bypass data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= gray_pixel_i;
      s1_fend_q <= frame_end_i;
      s1_col_q  <= cur_col;
      s1_emit_q <= (cur_row != '0) && (cur_col != '0);
      s1_full_q <= (cur_row > ROW_W'(1)) && (cur_col > COL_W'(1));
      fwd_up_q  <= mid_now;
      fwd_mid_q <= s1_pix_q;
    end
  end

  // line stores, read on accept, written when stage 1 completes
  let_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (mid_now),
    .re_i    (accept),
    .raddr_i (cur_col),
    .rdata_o (up_rdata)
  );

  let_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (accept),
    .raddr_i (cur_col),
    .rdata_o (mid_rdata)
  );

  assign up_now  = fwd_hit_q ? fwd_up_q  : up_rdata;
  assign mid_now = fwd_hit_q ? fwd_mid_q : mid_rdata;

  // centre is middle row at c-1; right neighbour is the middle row at c
  let_lap u_lap (
    .centre_i (mid_win1_q),
    .left_i   (mid_win0_q),
    .right_i  (mid_now),
    .upper_i  (upper_hold_q),
    .lower_i  (lower_hold_q),
    .thresh_i (thresh_q),
    .edge_o   (lap_edge)
  );

  // window shift as each pixel completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_win0_q   <= '0;
      mid_win1_q   <= '0;
      upper_hold_q <= '0;
      lower_hold_q <= '0;
    end else if (s1_adv) begin
      mid_win0_q   <= mid_win1_q;
      mid_win1_q   <= mid_now;
      upper_hold_q <= up_now;
      lower_hold_q <= s1_pix_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      edge_q <= (s1_full_q && lap_edge) ? EDGE_ON : EDGE_OFF;
      last_q <= s1_fend_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign edge_pixel_o    = edge_q;
  assign last_of_frame_o = last_q;

endmodule

// ===== rtl/let_ram.sv =====
// generic single-write, single-read ram with registered read-first output
// no dependencies
module let_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/let_lap.sv =====
// 4-neighbour laplacian, magnitude saturated at 255, threshold compare
// depends on let_pkg
module let_lap (
  input  logic [let_pkg::PIX_W-1:0]    centre_i,
  input  logic [let_pkg::PIX_W-1:0]    left_i,
  input  logic [let_pkg::PIX_W-1:0]    right_i,
  input  logic [let_pkg::PIX_W-1:0]    upper_i,
  input  logic [let_pkg::PIX_W-1:0]    lower_i,
  input  logic [let_pkg::THRESH_W-1:0] thresh_i,
  output logic                         edge_o
);
  import let_pkg::*;

  localparam int LAP_W = PIX_W + 3;

  logic signed [LAP_W-1:0] lap;
  logic        [LAP_W-1:0] mag;
  logic        [PIX_W-1:0] mag_sat;

  always_comb begin
    lap = $signed({1'b0, centre_i, 2'b00})
        - $signed({3'b000, left_i})
        - $signed({3'b000, right_i})
        - $signed({3'b000, upper_i})
        - $signed({3'b000, lower_i});
    mag = lap[LAP_W-1] ? LAP_W'(-lap) : LAP_W'(lap);
    mag_sat = (mag > LAP_W'(EDGE_ON)) ? EDGE_ON : mag[PIX_W-1:0];
    edge_o = mag_sat > thresh_i;
  end

endmodule

// ===== tb/let_checker.sv =====
// result checker for the laplacian edge thresholder: watches the config port and both
// channels, predicts each edge result and compares it with what the block returns
// depends on let_pkg
`timescale 1ns / 100ps

module let_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [let_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [let_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [let_pkg::PIX_W-1:0]      gray_pixel_i,
  input  logic                           frame_start_i,
  input  logic                           frame_end_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [let_pkg::PIX_W-1:0]      edge_pixel_i,
  input  logic                           last_of_frame_i,
  output int unsigned                    errors_o,
  output int unsigned                    pending_o
);
  import let_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] edge_pixel;
    logic             last_of_frame;
  } edge_result_t;

  edge_result_t edge_queue[$];
  edge_result_t oldest;
  int unsigned  error_count = 0;

  // shadow of the block: two lines, window and position
  bit   [PIX_W-1:0]        upper_line  [MAX_LINE_WIDTH];
  bit   [PIX_W-1:0]        middle_line [MAX_LINE_WIDTH];
  logic [COL_W-1:0]        col_pos;
  logic [ROW_W-1:0]        row_pos;
  logic [PIX_W-1:0]        win_left, win_centre, upper_hold, lower_hold;
  logic [LINE_WIDTH_W-1:0] width_reg;
  logic [THRESH_W-1:0]     thresh_reg;

  function automatic int unsigned active_width();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_LINE_WIDTH) return MAX_LINE_WIDTH;
    return width_reg;
  endfunction

  task automatic predict_edge(input logic [PIX_W-1:0] pix, input logic fs, input logic fe);
    int unsigned      w;
    int unsigned      col;
    int               lap;
    int               mag;
    logic [PIX_W-1:0] up_now;
    logic [PIX_W-1:0] mid_now;
    edge_result_t     res;
    w = active_width();
    if (fs) begin
      col_pos = '0;
      row_pos = '0;
    end
    col     = col_pos;
    up_now  = upper_line[col];
    mid_now = middle_line[col];
    if (row_pos >= 1 && col >= 1) begin
      res.edge_pixel    = EDGE_OFF;
      res.last_of_frame = fe;
      if (row_pos >= 2 && col >= 2) begin
        lap = 4 * int'(win_centre) - int'(win_left) - int'(mid_now)
              - int'(upper_hold) - int'(lower_hold);
        mag = (lap < 0) ? -lap : lap;
        if (mag > 255) mag = 255;
        if (mag > int'(thresh_reg)) res.edge_pixel = EDGE_ON;
      end
      edge_queue.push_back(res);
    end
    upper_line[col]  = mid_now;
    middle_line[col] = pix;
    win_left   = win_centre;
    win_centre = mid_now;
    upper_hold = up_now;
    lower_hold = pix;
    if (fe) begin
      col_pos = '0;
      row_pos = '0;
    end else if (col + 1 >= w) begin
      col_pos = '0;
      if (row_pos != ROW_MAX) row_pos = row_pos + 1'b1;
    end else begin
      col_pos = COL_W'(col + 1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos    = '0;
      row_pos    = '0;
      win_left   = '0;
      win_centre = '0;
      upper_hold = '0;
      lower_hold = '0;
      width_reg  = LINE_WIDTH_RST;
      thresh_reg = THRESH_RST;
      edge_queue.delete();
      pending_o <= 0;
      errors_o  <= error_count;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (edge_queue.size() == 0) begin
          error_count++;
          $display("%0t: result with no request pending, expected none, actual %0d/%0b",
                   $time, edge_pixel_i, last_of_frame_i);
        end else begin
          oldest = edge_queue.pop_front();
          if (edge_pixel_i !== oldest.edge_pixel) begin
            error_count++;
            $display("%0t: edge_pixel mismatch, expected %0d, actual %0d",
                     $time, oldest.edge_pixel, edge_pixel_i);
          end
          if (last_of_frame_i !== oldest.last_of_frame) begin
            error_count++;
            $display("%0t: last_of_frame mismatch, expected %0b, actual %0b",
                     $time, oldest.last_of_frame, last_of_frame_i);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LINE_WIDTH:     width_reg = cfg_data_i[LINE_WIDTH_W-1:0];
          REG_EDGE_THRESHOLD: thresh_reg = cfg_data_i[THRESH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_edge(gray_pixel_i, frame_start_i, frame_end_i);
      pending_o <= edge_queue.size();
      errors_o  <= error_count;
    end
  end

endmodule

// ===== tb/tb.sv =====
// top of the laplacian edge thresholder testbench: clock, reset, config writes and
// pixel stimulus with random idling; depends on let_pkg, the rtl and let_checker
`timescale 1ns / 100ps

module tb;
  import let_pkg::*;

  typedef enum int unsigned {PIX_NOISE, PIX_FLAT, PIX_BINARY} pix_style_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = REG_LINE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic [PIX_W-1:0]      gray_pixel_i  = '0;
  logic                  frame_start_i = 1'b0;
  logic                  frame_end_i   = 1'b0;
  logic                  out_stall_i   = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [PIX_W-1:0]      edge_pixel_o;
  logic                  last_of_frame_o;

  int unsigned mismatch_count;
  int unsigned results_owed;

  // idle and stall odds in percent, changed per phase
  int unsigned idle_pct   = 9;
  int unsigned stall_pct  = 49;
  // clamped width the block is using, for shaping frames
  int unsigned width_now  = LINE_WIDTH_RST;
  int unsigned pixels_sent = 0;
  // last request carried a frame end, so row and column are back at zero
  bit          frame_closed = 1'b1;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b0;
    #1 clk_i = 1'b1;
  end

  laplacian_edge_threshold i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .gray_pixel_i    (gray_pixel_i),
    .frame_start_i   (frame_start_i),
    .frame_end_i     (frame_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .edge_pixel_o    (edge_pixel_o),
    .last_of_frame_o (last_of_frame_o)
  );

  let_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .gray_pixel_i    (gray_pixel_i),
    .frame_start_i   (frame_start_i),
    .frame_end_i     (frame_end_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .edge_pixel_i    (edge_pixel_o),
    .last_of_frame_i (last_of_frame_o),
    .errors_o        (mismatch_count),
    .pending_o       (results_owed)
  );

  // receiver back-pressure, fresh draw every cycle
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // one pixel request; returns in the time step of the edge that took it
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs, input logic fe);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    gray_pixel_i  <= pix;
    frame_start_i <= fs;
    frame_end_i   <= fe;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    frame_closed = fe;
    pixels_sent++;
  endtask

  // stop sending, wait for every owed result, then give the pipeline time to settle
  // (pixels in the first row or column owe nothing but may still be in flight)
  task automatic drain();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (results_owed != 0 && guard < 5000);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic configure(input int unsigned width, input int unsigned thresh);
    write_reg(REG_LINE_WIDTH, width);
    write_reg(REG_EDGE_THRESHOLD, thresh);
    width_now = (width < 3) ? 3 : (width > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : width;
  endtask

  // npix pixels in raster order; frame start may be dropped when the last frame closed
  // cleanly, and a few stray start or end marks land anywhere
  task automatic send_frame(input int unsigned npix, input pix_style_e style,
                            input bit with_start, input bit with_end);
    int unsigned      base;
    logic [PIX_W-1:0] pix;
    logic             fs;
    logic             fe;
    base = $urandom_range(243, 12);
    for (int unsigned k = 0; k < npix; k++) begin
      case (style)
        PIX_NOISE: pix = PIX_W'($urandom_range(255));
        PIX_FLAT:  pix = PIX_W'(base + $urandom_range(24) - 12);
        default:   pix = $urandom_range(1) ? EDGE_ON : EDGE_OFF;
      endcase
      fs = with_start && (k == 0) && !(frame_closed && $urandom_range(7) == 0);
      fe = with_end && (k == npix - 1);
      if ($urandom_range(59) == 0) begin
        fs = fs | 1'($urandom_range(1));
        fe = fe | 1'($urandom_range(1));
      end
      send_pixel(pix, fs, fe);
    end
  endtask

  // narrow the line in the middle of a frame, sometimes below the current column
  task automatic shrink_mid_frame();
    int unsigned cut;
    cut = $urandom_range(9);
    drain();
    configure(10, $urandom_range(64));
    send_frame(2 * 10 + cut, PIX_NOISE, 1'b1, 1'b0);
    drain();
    configure($urandom_range(10), $urandom_range(64));
    send_frame(3 * width_now + 1, PIX_NOISE, 1'b0, 1'b1);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned target);
    int unsigned start;
    int unsigned rows;
    int unsigned total;
    int unsigned width;
    int unsigned thresh;
    pix_style_e  style;
    idle_pct  = idle;
    stall_pct = stall;
    start     = pixels_sent;
    shrink_mid_frame();
    while (pixels_sent - start < target) begin
      drain();
      case ($urandom_range(4))
        0:       width = $urandom_range(2);     // clamped up to three
        1:       width = 3;
        default: width = $urandom_range(12, 4);
      endcase
      case ($urandom_range(4))
        0:       thresh = 0;
        1:       thresh = 255;
        2:       thresh = $urandom_range(255);
        default: thresh = $urandom_range(64);
      endcase
      configure(width, thresh);
      repeat ($urandom_range(3, 1)) begin
        rows  = $urandom_range(5, 1);
        total = rows * width_now;
        style = pix_style_e'($urandom_range(2));
        // mostly whole frames, some cut short with or without an end mark
        if ($urandom_range(4) == 0)
          send_frame($urandom_range(total - 1, 1), style, 1'b1, 1'($urandom_range(1)));
        else
          send_frame(total, style, 1'b1, 1'b1);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset width of 640: a short frame stays in the first row and owes nothing
    send_frame(80, PIX_NOISE, 1'b1, 1'b1);

    // reset threshold of 30 on a narrow line
    drain();
    write_reg(REG_LINE_WIDTH, 4);
    width_now = 4;
    send_frame(16, PIX_FLAT, 1'b1, 1'b1);

    // directed: width below range, saturated magnitude just over the threshold
    drain();
    configure(2, 254);
    // bright centre on black
    for (int unsigned k = 0; k < 9; k++)
      send_pixel((k == 4) ? EDGE_ON : EDGE_OFF, k == 0, k == 8);
    // black centre on white, extra row
    for (int unsigned k = 0; k < 12; k++)
      send_pixel((k == 4) ? EDGE_OFF : EDGE_ON, k == 0, k == 11);
    // lone pixel that starts and ends a frame, owes no result
    send_pixel(8'h5A, 1'b1, 1'b1);

    run_phase(9, 49, 60);
    run_phase(49, 9, 60);
    run_phase(0, 0, 60);

    // out of range width clamps to the widest line; a short frame stays in its first row
    drain();
    configure(2047, $urandom_range(64));
    send_frame(40, PIX_FLAT, 1'b1, 1'b1);

    drain();
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
